[rtl/core/sic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sic_pkg
// shared types, widths and status codes for the segment insert block
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int COORD_W          = 16;
  localparam int STATUS_W         = 2;
  localparam int SLOT_W           = 8;
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int COORD_BITS_DEF   = 16;

  localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEGEN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CROSS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
  } seg_t;

endpackage

`default_nettype wire

[rtl/core/sic_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sic_in_if
// proposal channel: valid/ready with the two segment endpoints
// ----------------------------------------------------------------------------
interface sic_in_if;
  import sic_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y,
                  input end_x, input end_y, output ready);
endinterface

`default_nettype wire

[rtl/core/sic_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sic_out_if
// result channel: valid/ready with status and slot index
// ----------------------------------------------------------------------------
interface sic_out_if;
  import sic_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

[rtl/core/sic_seg_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sic_seg_mem
// segment table, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module sic_seg_mem
  import sic_pkg::*;
#(
  parameter int DEPTH = MAX_SEGMENTS_DEF,
  parameter int IDX_W = $clog2(MAX_SEGMENTS_DEF)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire seg_t             wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output seg_t                  rd_data
);

  seg_t mem [DEPTH];
  seg_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/sic_cross_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sic_cross_unit
// two-stage crossing test of the proposal against one stored segment:
// products registered, then signs, dot product and bounding boxes
// ----------------------------------------------------------------------------
module sic_cross_unit
  import sic_pkg::*;
(
  input  wire logic   clk,
  input  wire point_t s,
  input  wire point_t e,
  input  wire seg_t   o,
  output logic        hit
);

  localparam int DIF_W = COORD_W + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int ACC_W = PRD_W + 1;

  typedef logic signed [DIF_W-1:0] dif_t;
  typedef logic signed [PRD_W-1:0] prd_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic dif_t sub_c(input coord_t a, input coord_t b);
    dif_t ea;
    dif_t eb;
    ea = DIF_W'(a);
    eb = DIF_W'(b);
    return ea - eb;
  endfunction

  function automatic logic in_box(input point_t p, input point_t q, input point_t r);
    logic bx;
    logic by;
    bx = (p.x <= q.x && q.x <= r.x) || (r.x <= q.x && q.x <= p.x);
    by = (p.y <= q.y && q.y <= r.y) || (r.y <= q.y && q.y <= p.y);
    return bx && by;
  endfunction

  // stage a: differences and products
  dif_t dxe, dye, dxo, dyo, mdx, mdy, tdx, tdy;
  logic sa, sb, ea, eb, at_start, theirs_b;
  point_t pivot, theirs;

  always_comb begin
    dxe      = sub_c(e.x, s.x);
    dye      = sub_c(e.y, s.y);
    dxo      = sub_c(o.b.x, o.a.x);
    dyo      = sub_c(o.b.y, o.a.y);
    sa       = (s == o.a);
    sb       = (s == o.b);
    ea       = (e == o.a);
    eb       = (e == o.b);
    at_start = sa | sb;
    theirs_b = sa | ea;
    pivot    = at_start ? s : e;
    theirs   = theirs_b ? o.b : o.a;
    mdx      = at_start ? dxe : -dxe;
    mdy      = at_start ? dye : -dye;
    tdx      = sub_c(theirs.x, pivot.x);
    tdy      = sub_c(theirs.y, pivot.y);
  end

  prd_t p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r, p4a_r, p4b_r, pdx_r, pdy_r;
  logic single_r, theirs_b_r;
  seg_t o_r;

  always_ff @(posedge clk) begin
    p1a_r      <= dxe * sub_c(o.a.y, s.y);
    p1b_r      <= dye * sub_c(o.a.x, s.x);
    p2a_r      <= dxe * sub_c(o.b.y, s.y);
    p2b_r      <= dye * sub_c(o.b.x, s.x);
    p3a_r      <= dxo * sub_c(s.y, o.a.y);
    p3b_r      <= dyo * sub_c(s.x, o.a.x);
    p4a_r      <= dxo * sub_c(e.y, o.a.y);
    p4b_r      <= dyo * sub_c(e.x, o.a.x);
    pdx_r      <= mdx * tdx;
    pdy_r      <= mdy * tdy;
    single_r   <= $onehot({sa, sb, ea, eb});
    theirs_b_r <= theirs_b;
    o_r        <= o;
  end

  // stage b: orientation signs and final decision
  acc_t c1, c2, c3, c4, dot;
  logic z1, z2, z3, z4, n1, n2, n3, n4;
  logic general, single_hit;

  always_comb begin
    c1 = ACC_W'(p1a_r) - ACC_W'(p1b_r);
    c2 = ACC_W'(p2a_r) - ACC_W'(p2b_r);
    c3 = ACC_W'(p3a_r) - ACC_W'(p3b_r);
    c4 = ACC_W'(p4a_r) - ACC_W'(p4b_r);
    dot = ACC_W'(pdx_r) + ACC_W'(pdy_r);
    z1 = (c1 == '0);
    z2 = (c2 == '0);
    z3 = (c3 == '0);
    z4 = (c4 == '0);
    n1 = c1[ACC_W-1];
    n2 = c2[ACC_W-1];
    n3 = c3[ACC_W-1];
    n4 = c4[ACC_W-1];
    general = (((z1 != z2) || (n1 != n2)) && ((z3 != z4) || (n3 != n4))) ||
              (z1 && in_box(s, o_r.a, e)) ||
              (z2 && in_box(s, o_r.b, e)) ||
              (z3 && in_box(o_r.a, s, o_r.b)) ||
              (z4 && in_box(o_r.a, e, o_r.b));
    single_hit = (theirs_b_r ? z2 : z1) && !dot[ACC_W-1] && (dot != '0);
    hit = single_r ? single_hit : general;
  end

endmodule

`default_nettype wire

[rtl/core/segment_insert_with_crossing_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_insert_with_crossing_check
// checks a proposed segment against all stored segments and stores it
// when it is not degenerate, nothing crosses and the table has room
// ----------------------------------------------------------------------------
// each stored segment is compared with the proposal in turn, then the proposal is
// written and reported (degenerate proposals skip scan and write, a crossing ends
// the scan early, a full table skips the write, an empty table skips the scan);
// one stored segment is read per cycle through the single table read port, and a new proposal waits for the result
// reset clears the segment count and all control; table contents are not cleared
module segment_insert_with_crossing_check
  import sic_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sic_in_if.sink     in_seg,
  sic_out_if.source  out_res
);

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int USED_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int SH     = COORD_W - USED_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  function automatic coord_t fit(input coord_t raw);
    coord_t t;
    t = raw << SH;
    return t >>> SH;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                a_v_r, a_v_nxt, b_v_r, b_v_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  point_t              s_r, s_nxt, e_r, e_nxt;

  point_t in_s, in_e;
  logic   in_xfer, issue, hit, found, full;
  seg_t   rd_data, wr_data;

  assign in_s.x  = fit(in_seg.start_x);
  assign in_s.y  = fit(in_seg.start_y);
  assign in_e.x  = fit(in_seg.end_x);
  assign in_e.y  = fit(in_seg.end_y);
  assign in_seg.ready = (state_r == S_IDLE);
  assign in_xfer = in_seg.valid && in_seg.ready;
  assign issue   = (state_r == S_SCAN);
  assign found   = b_v_r && hit;
  assign full    = (cnt_r >= CNT_W'(MAX_SEGMENTS));
  assign wr_data.a = s_r;
  assign wr_data.b = e_r;

  sic_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (state_r == S_WRITE),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  sic_cross_unit u_cross (
    .clk (clk),
    .s   (s_r),
    .e   (e_r),
    .o   (rd_data),
    .hit (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    a_v_nxt        = issue;
    b_v_nxt        = a_v_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          s_nxt        = in_s;
          e_nxt        = in_e;
          rd_idx_nxt   = '0;
          res_slot_nxt = '0;
          if (in_s == in_e) begin
            res_status_nxt = ST_DEGEN;
            state_nxt      = S_DONE;
          end else if (cnt_r == '0) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (found) begin
          res_status_nxt = ST_CROSS;
          state_nxt      = S_DONE;
          a_v_nxt        = 1'b0;
          b_v_nxt        = 1'b0;
        end else if (CNT_W'(rd_idx_r) == cnt_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (found) begin
          res_status_nxt = ST_CROSS;
          state_nxt      = S_DONE;
          a_v_nxt        = 1'b0;
          b_v_nxt        = 1'b0;
        end else if (!a_v_r && !b_v_r) begin
          if (full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        res_status_nxt = ST_STORED;
        res_slot_nxt   = SLOT_W'(cnt_r);
        cnt_nxt        = cnt_r + CNT_W'(1);
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      a_v_r       <= a_v_nxt;
      b_v_r       <= b_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.status     = out_status_r;
  assign out_res.slot_index = out_slot_r;

  // count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above table depth");

  // a store bumps the count by exactly one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("segment count not advanced on store");

  // compare results only in flight while scanning
  a_pipe_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("compare pipeline valid outside scan");

  // stored result always reports the slot it used
  a_store_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (res_slot_r == SLOT_W'($past(cnt_r))))
    else $error("stored slot mismatch");

endmodule

`default_nettype wire
